>>> design/vdbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdbd_pkg
// Types, constants and helper functions shared by the vertex delta bitstream
// decoder modules.
// ----------------------------------------------------------------------------
package vdbd_pkg;

    // sizing
    localparam int MAX_VERTICES    = 1024;
    localparam int MAX_FIELD_WIDTH = 16;
    localparam int ADDR_W          = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CNT_W           = ADDR_W + 1;
    localparam int COUNT_W         = 11;
    localparam int INDEX_W         = 10;
    localparam int COORD_W         = 8;
    localparam int FIELD_W         = 5;
    localparam int WORD_W          = 32;
    localparam int BUF_W           = 64;
    localparam int HELD_W          = 7;
    localparam int FRAME_W         = 16;
    localparam int LANE_OFS_W      = 6;

    // operation codes
    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_PUSH   = 2'd1,
        OP_DECODE = 2'd2,
        OP_IDLE   = 2'd3
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_STARVED = 2'd1,
        ST_FULL    = 2'd2,
        ST_RANGE   = 2'd3
    } t_status;

    // input transaction payload
    typedef struct packed {
        logic [1:0]         operation;
        logic [INDEX_W-1:0] vertex_index;
        logic [COORD_W-1:0] base_x;
        logic [COORD_W-1:0] base_y;
        logic [COORD_W-1:0] base_z;
        logic [FIELD_W-1:0] width_x;
        logic [FIELD_W-1:0] width_y;
        logic [FIELD_W-1:0] width_z;
        logic [WORD_W-1:0]  stream_word;
    } t_in_item;

    // output transaction payload
    typedef struct packed {
        logic [INDEX_W-1:0] out_vertex;
        logic [COORD_W-1:0] value_x;
        logic [COORD_W-1:0] value_y;
        logic [COORD_W-1:0] value_z;
        logic [FRAME_W-1:0] frame_number;
        logic               frame_done;
        logic [1:0]         status;
    } t_out_item;

    // one vertex memory entry
    typedef struct packed {
        logic [FIELD_W-1:0] width_z;
        logic [FIELD_W-1:0] width_y;
        logic [FIELD_W-1:0] width_x;
        logic [COORD_W-1:0] coord_z;
        logic [COORD_W-1:0] coord_y;
        logic [COORD_W-1:0] coord_x;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // decoder state carried between transactions
    typedef struct packed {
        logic [BUF_W-1:0]   bit_buf;
        logic [HELD_W-1:0]  bits_held;
        logic [ADDR_W-1:0]  next_vertex;
        logic [FRAME_W-1:0] frame_total;
    } t_core_state;

    // vertex memory write request
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        t_entry            data;
    } t_mem_wr;

    // width clamp applied when a vertex is loaded
    function automatic logic [FIELD_W-1:0] f_clamp_width(input logic [FIELD_W-1:0] w);
        logic [FIELD_W-1:0] r;
        r = (32'(w) > MAX_FIELD_WIDTH) ? FIELD_W'(MAX_FIELD_WIDTH) : w;
        return r;
    endfunction

    // vertices per frame, limited to 1 .. MAX_VERTICES
    function automatic logic [CNT_W-1:0] f_count_eff(input logic [COUNT_W-1:0] vc);
        logic [CNT_W-1:0] r;
        if (vc == '0) begin
            r = CNT_W'(1);
        end else if (32'(vc) > MAX_VERTICES) begin
            r = CNT_W'(MAX_VERTICES);
        end else begin
            r = CNT_W'(vc);
        end
        return r;
    endfunction

endpackage

>>> design/vdbd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdbd_ram
// Generic single write port, single read port RAM with registered read data.
// A read and a write of the same address in one cycle return the old data.
// ----------------------------------------------------------------------------
module vdbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                          i_wr_data,
    input  logic                                      i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                          o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/vdbd_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdbd_lane
// One axis lane: picks a two's complement delta field out of the bit buffer at
// a given offset and adds it to the stored coordinate modulo 256.
// ----------------------------------------------------------------------------
module vdbd_lane import vdbd_pkg::*; (
    input  logic [BUF_W-1:0]      i_buf,
    input  logic [LANE_OFS_W-1:0] i_offset,
    input  logic [FIELD_W-1:0]    i_width,
    input  logic [COORD_W-1:0]    i_coord,
    output logic [COORD_W-1:0]    o_value
);

    logic [BUF_W-1:0]           shifted;
    logic [MAX_FIELD_WIDTH-1:0] field;
    logic [FIELD_W-1:0]         width_m1;
    logic                       sign;
    logic [COORD_W-1:0]         delta;

    // field bits start at the lane offset
    assign shifted  = i_buf >> i_offset;
    assign field    = shifted[MAX_FIELD_WIDTH-1:0];
    assign width_m1 = i_width - FIELD_W'(1);

    // sign extend the low byte of the field; zero width gives zero
    always_comb begin
        sign = (i_width == '0) ? 1'b0 : field[width_m1[$clog2(MAX_FIELD_WIDTH)-1:0]];
        for (int j = 0; j < COORD_W; j++) begin
            delta[j] = (32'(j) < 32'(i_width)) ? field[j] : sign;
        end
    end

    // wrapping add
    assign o_value = i_coord + delta;

endmodule

>>> design/vdbd_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdbd_exec
// Execute stage: three axis lanes decode their delta fields side by side and
// the merge logic checks the bit supply, consumes the bits, updates the vertex
// pointer and frame count, and forms the result and the memory write.
// ----------------------------------------------------------------------------
module vdbd_exec import vdbd_pkg::*; (
    input  t_in_item            i_item,
    input  t_core_state         i_state,
    input  t_entry              i_entry,
    input  logic [COUNT_W-1:0]  i_vertex_count,
    output t_core_state         o_state,
    output t_out_item           o_result,
    output t_mem_wr             o_mem_wr
);

    logic [LANE_OFS_W-1:0] ofs_y;
    logic [LANE_OFS_W-1:0] ofs_z;
    logic [COORD_W-1:0]    lane_x;
    logic [COORD_W-1:0]    lane_y;
    logic [COORD_W-1:0]    lane_z;
    logic [HELD_W-1:0]     total_bits;
    logic [CNT_W-1:0]      count_eff;
    logic [CNT_W-1:0]      ptr_inc;
    logic [FRAME_W-1:0]    frame_inc;
    logic                  idx_ok;
    t_entry                load_entry;

    // field offsets within the buffer
    assign ofs_y = LANE_OFS_W'(i_entry.width_x);
    assign ofs_z = LANE_OFS_W'(i_entry.width_x) + LANE_OFS_W'(i_entry.width_y);

    // axis lanes
    vdbd_lane u_lane_x (
        .i_buf    (i_state.bit_buf),
        .i_offset ('0),
        .i_width  (i_entry.width_x),
        .i_coord  (i_entry.coord_x),
        .o_value  (lane_x)
    );

    vdbd_lane u_lane_y (
        .i_buf    (i_state.bit_buf),
        .i_offset (ofs_y),
        .i_width  (i_entry.width_y),
        .i_coord  (i_entry.coord_y),
        .o_value  (lane_y)
    );

    vdbd_lane u_lane_z (
        .i_buf    (i_state.bit_buf),
        .i_offset (ofs_z),
        .i_width  (i_entry.width_z),
        .i_coord  (i_entry.coord_z),
        .o_value  (lane_z)
    );

    // shared terms
    assign total_bits = HELD_W'(i_entry.width_x) + HELD_W'(i_entry.width_y)
                      + HELD_W'(i_entry.width_z);
    assign count_eff  = f_count_eff(i_vertex_count);
    assign ptr_inc    = {1'b0, i_state.next_vertex} + CNT_W'(1);
    assign frame_inc  = i_state.frame_total + FRAME_W'(1);
    assign idx_ok     = (32'(i_item.vertex_index) < MAX_VERTICES);

    // entry written by a load
    always_comb begin
        load_entry.width_x = f_clamp_width(i_item.width_x);
        load_entry.width_y = f_clamp_width(i_item.width_y);
        load_entry.width_z = f_clamp_width(i_item.width_z);
        load_entry.coord_x = i_item.base_x;
        load_entry.coord_y = i_item.base_y;
        load_entry.coord_z = i_item.base_z;
    end

    // merge: per-operation state update, result and write
    always_comb begin
        o_state               = i_state;
        o_result.out_vertex   = INDEX_W'(i_state.next_vertex);
        o_result.value_x      = '0;
        o_result.value_y      = '0;
        o_result.value_z      = '0;
        o_result.frame_number = i_state.frame_total;
        o_result.frame_done   = 1'b0;
        o_result.status       = ST_OK;
        o_mem_wr.en           = 1'b0;
        o_mem_wr.addr         = i_state.next_vertex;
        o_mem_wr.data         = i_entry;

        case (t_op'(i_item.operation))
            OP_LOAD: begin
                o_result.out_vertex   = i_item.vertex_index;
                o_result.value_x      = i_item.base_x;
                o_result.value_y      = i_item.base_y;
                o_result.value_z      = i_item.base_z;
                o_result.frame_number = '0;
                o_mem_wr.addr         = ADDR_W'(i_item.vertex_index);
                o_mem_wr.data         = load_entry;
                if (idx_ok) begin
                    o_mem_wr.en = 1'b1;
                end else begin
                    o_result.status = ST_RANGE;
                end
                o_state.bit_buf     = '0;
                o_state.bits_held   = '0;
                o_state.next_vertex = '0;
                o_state.frame_total = '0;
            end
            OP_PUSH: begin
                if (32'(i_state.bits_held) > WORD_W) begin
                    o_result.status = ST_FULL;
                end else begin
                    o_state.bit_buf   = i_state.bit_buf
                                      | (BUF_W'(i_item.stream_word) << i_state.bits_held);
                    o_state.bits_held = i_state.bits_held + HELD_W'(WORD_W);
                end
            end
            OP_DECODE: begin
                if ({1'b0, i_state.next_vertex} >= count_eff) begin
                    o_result.status     = ST_RANGE;
                    o_state.next_vertex = '0;
                end else if (total_bits > i_state.bits_held) begin
                    o_result.status  = ST_STARVED;
                    o_result.value_x = i_entry.coord_x;
                    o_result.value_y = i_entry.coord_y;
                    o_result.value_z = i_entry.coord_z;
                end else begin
                    o_result.value_x      = lane_x;
                    o_result.value_y      = lane_y;
                    o_result.value_z      = lane_z;
                    o_result.frame_number = frame_inc;
                    o_mem_wr.en           = 1'b1;
                    o_mem_wr.data.coord_x = lane_x;
                    o_mem_wr.data.coord_y = lane_y;
                    o_mem_wr.data.coord_z = lane_z;
                    o_state.bit_buf       = i_state.bit_buf >> total_bits;
                    o_state.bits_held     = i_state.bits_held - total_bits;
                    if (ptr_inc >= count_eff) begin
                        o_state.next_vertex = '0;
                        o_state.frame_total = frame_inc;
                        o_result.frame_done = 1'b1;
                    end else begin
                        o_state.next_vertex = ADDR_W'(ptr_inc);
                    end
                end
            end
            default: begin
                // unused selector: no change, default result
            end
        endcase
    end

endmodule

>>> design/vertex_delta_bitstream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_delta_bitstream_decoder
// Decodes a packed delta stream of quantized 8-bit vertex positions. Loads
// write a vertex's base position and field widths, words feed a 64-bit bit
// buffer, decodes add three sign-extended fields to the next vertex.
//
// channel  direction  handshake                  payload
// in       input      i_in_valid / o_in_ready    i_in_data   (t_in_item)
// out      output     o_out_valid / i_out_ready  o_out_data  (t_out_item)
// cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_data  (vertex_count)
//
// One transaction per cycle unless the output stalls; results are registered.
// The rate is set by the execute stage loop: width sum, bit supply compare,
// buffer shift and next vertex address into the vertex RAM read port.
// Synchronous active-low reset clears the buffer, pointer and frame count and
// sets vertex_count to 1; vertex RAM contents stay undefined until loaded.
// A stalled output holds the execute stage, which then holds input ready low.
// ----------------------------------------------------------------------------
module vertex_delta_bitstream_decoder import vdbd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in_item            i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_item           o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [COUNT_W-1:0]  i_cfg_data
);

    logic [COUNT_W-1:0] r_vertex_count;
    t_core_state        r_state;
    t_core_state        n_state;
    logic               r_s1_valid;
    t_in_item           r_s1_item;
    logic               r_fwd_hit;
    t_entry             r_fwd_data;
    logic               r_out_valid;
    t_out_item          r_out_data;
    t_out_item          exec_result;
    t_mem_wr            exec_wr;
    t_entry             ram_rd_data;
    t_entry             s1_entry;
    logic [ADDR_W-1:0]  rd_addr;
    logic               in_accept;
    logic               s1_fire;

    // handshakes
    assign s1_fire     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_s1_valid || s1_fire;
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= COUNT_W'(1);
        end else if (i_cfg_valid) begin
            r_vertex_count <= i_cfg_data;
        end
    end

    // read the entry at the pointer the executing transaction leaves behind
    assign rd_addr = s1_fire ? n_state.next_vertex : r_state.next_vertex;

    vdbd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_VERTICES)
    ) u_vertex_ram (
        .i_clk     (i_clk),
        .i_wr_en   (s1_fire && exec_wr.en),
        .i_wr_addr (exec_wr.addr),
        .i_wr_data (exec_wr.data),
        .i_rd_en   (in_accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // bypass for a write and read of the same entry on one edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (in_accept) begin
            r_fwd_hit <= s1_fire && exec_wr.en && (exec_wr.addr == rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_fwd_data <= exec_wr.data;
        end
    end

    assign s1_entry = r_fwd_hit ? r_fwd_data : ram_rd_data;

    // execute stage holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_item <= i_in_data;
        end
    end

    vdbd_exec u_exec (
        .i_item         (r_s1_item),
        .i_state        (r_state),
        .i_entry        (s1_entry),
        .i_vertex_count (r_vertex_count),
        .o_state        (n_state),
        .o_result       (exec_result),
        .o_mem_wr       (exec_wr)
    );

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (s1_fire) begin
            r_state <= n_state;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_data <= exec_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
